// File: hw/rtl/ifc_pkg.sv
// ----------------------------------------------------------------------------
// ifc_pkg
// Shared types, codes and constant arithmetic for the irrigation and fan
// controller.
// ----------------------------------------------------------------------------
package ifc_pkg;

   // event kinds
   localparam logic [1:0] KIND_CONTROL = 2'd0;
   localparam logic [1:0] KIND_RAMP    = 2'd1;
   localparam logic [1:0] KIND_TOGGLE  = 2'd2;
   localparam logic [1:0] KIND_ECO     = 2'd3;

   // operating modes
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_SAVER  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_DRY_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_PUMP_DURATION = 2'd1;
   localparam logic [1:0] CSR_COOLDOWN      = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [6:0]  DRY_THRESHOLD_RST = 7'd40;
   localparam logic [15:0] PUMP_DURATION_RST = 16'd3000;
   localparam logic [15:0] COOLDOWN_RST      = 16'd10000;

   // moisture calibration
   localparam int unsigned DRY_RAW    = 996;
   localparam int unsigned WET_RAW    = 385;
   localparam int unsigned MOIST_SPAN = DRY_RAW - WET_RAW;
   localparam int unsigned PCT_FULL   = 100;
   localparam int unsigned ECO_MARGIN = 10;

   // light: lux = dark * 1000 / 1023, where dark = 1023 - raw
   localparam int unsigned LUX_DEN     = 1023;
   localparam int unsigned LUX_SCALE   = 1000;
   localparam int unsigned EVENING_LUX = 100;
   // largest dark count whose lux stays below the evening level
   localparam int unsigned EVENING_DARK_MAX = (EVENING_LUX * LUX_DEN - 1) / LUX_SCALE;

   // fan temperature steps
   localparam logic [7:0] TEMP_WARM = 8'd25;
   localparam logic [7:0] TEMP_HOT  = 8'd30;
   localparam logic [7:0] TEMP_VERY = 8'd35;
   localparam logic [6:0] FAN_LOW   = 7'd30;
   localparam logic [6:0] FAN_MID   = 7'd60;
   localparam logic [6:0] FAN_FULL  = 7'd100;

   // duty = percent * 255 / 100, division by reciprocal (exact below 43699)
   localparam int unsigned DUTY_MAX    = 255;
   localparam int unsigned DUTY_RECIP  = 5243;
   localparam int unsigned DUTY_SHIFT  = 19;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
      logic [9:0]  moist_sample;
      logic [9:0]  light_sample;
      logic [7:0]  temperature;
      logic        water_present;
   } ifc_item_type;

   typedef struct packed {
      logic [6:0]  dry_threshold;
      logic [15:0] pump_duration_ms;
      logic [15:0] cooldown_ms;
   } ifc_cfg_type;

   typedef struct packed {
      logic       pump_on;
      logic [6:0] fan_percent;
      logic [1:0] mode;
      logic       low_water_alarm;
   } ifc_result_type;

   // moisture percent scaled by the span: percent < t  iff  scaled < t * span
   function automatic logic [15:0] moist_scaled(input logic [9:0] raw);
      logic [9:0] diff;
      begin
         diff = 10'(DRY_RAW) - raw;
         if (raw >= 10'(DRY_RAW))
            moist_scaled = 16'd0;
         else if (raw <= 10'(WET_RAW))
            moist_scaled = 16'(PCT_FULL * MOIST_SPAN);
         else
            moist_scaled = 16'(diff) * 16'(PCT_FULL);
      end
   endfunction

   function automatic logic [16:0] thr_scaled(input logic [6:0] thr);
      thr_scaled = 17'(thr) * 17'(MOIST_SPAN);
   endfunction

   function automatic logic is_evening(input logic [9:0] raw);
      logic [9:0] dark;
      begin
         dark = 10'(LUX_DEN) - raw;
         is_evening = (dark <= 10'(EVENING_DARK_MAX));
      end
   endfunction

   function automatic logic [6:0] fan_target_of(input logic [1:0] mode,
                                                input logic [7:0] temp);
      if (mode == MODE_OFF)
         fan_target_of = 7'd0;
      else if (temp < TEMP_WARM)
         fan_target_of = 7'd0;
      else if (temp < TEMP_HOT)
         fan_target_of = FAN_LOW;
      else if (temp < TEMP_VERY)
         fan_target_of = FAN_MID;
      else
         fan_target_of = FAN_FULL;
   endfunction

   function automatic logic [7:0] duty_of(input logic [6:0] pct);
      logic [14:0] prod;
      logic [27:0] wide;
      begin
         prod = 15'(pct) * 15'(DUTY_MAX);
         wide = 28'(prod) * 28'(DUTY_RECIP);
         duty_of = 8'(wide >> DUTY_SHIFT);
      end
   endfunction

endpackage

// File: hw/rtl/irrigation_and_fan_controller.sv
// ----------------------------------------------------------------------------
// irrigation_and_fan_controller
// Event-driven pump and fan controller: control, ramp, toggle and eco events.
// ----------------------------------------------------------------------------
// usage
//   req_*  : one event beat (kind, timestamp, sensor samples); accepted when
//            req_valid is high and req_stall is low
//   rsp_*  : one result beat per event (pump, fan percent and duty, mode,
//            low-water alarm); taken when rsp_valid is high and rsp_stall low
//   csr_*  : register writes, index 0 dry threshold, 1 pump run time,
//            2 cooldown; csr_ready is always high, write only while idle
// path     : request beat to result beat through the input register, then
//            the result register
// throughput: one event per cycle unless stalled; the whole state update
//            for an event is one logic pass between input and result registers
// reset    : synchronous; system off, pump stopped, fan at rest, registers
//            back to 40 percent, 3000 ms and 10000 ms
// stall    : a stalled result holds; the input register still takes one
//            more beat, then req_stall rises until the result drains
// ----------------------------------------------------------------------------
module irrigation_and_fan_controller (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_kind,
   input  logic [31:0]                      req_now_ms,
   input  logic [9:0]                       req_moist_sample,
   input  logic [9:0]                       req_light_sample,
   input  logic [7:0]                       req_temperature,
   input  logic                             req_water_present,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_pump_on,
   output logic [6:0]                       rsp_fan_percent,
   output logic [7:0]                       rsp_fan_duty,
   output logic [1:0]                       rsp_mode,
   output logic                             rsp_low_water_alarm,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ifc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ifc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ifc_pkg::*;

   ifc_cfg_type    cfg;
   ifc_item_type   item_ff;
   ifc_result_type result;
   ifc_result_type rsp_ff;

   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept;
   logic advance;   // result register free or being drained
   logic fire;      // held beat moves into the result register

   assign csr_ready = 1'b1;

   ifc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // handshake
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && advance;
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register, payload only
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.kind          <= req_kind;
         item_ff.now_ms        <= req_now_ms;
         item_ff.moist_sample  <= req_moist_sample;
         item_ff.light_sample  <= req_light_sample;
         item_ff.temperature   <= req_temperature;
         item_ff.water_present <= req_water_present;
      end
   end

   ifc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (fire)
         rsp_ff <= result;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pump_on         = rsp_ff.pump_on;
   assign rsp_fan_percent     = rsp_ff.fan_percent;
   assign rsp_fan_duty        = duty_of(rsp_ff.fan_percent);
   assign rsp_mode            = rsp_ff.mode;
   assign rsp_low_water_alarm = rsp_ff.low_water_alarm;

`ifndef SYNTHESIS
   // back-pressure only when both stages hold a beat and the output is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipe");

   // a moved beat always shows up as a result beat
   a_fire_shows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("moved beat lost before the result register");

   // an alarm result never reports the pump on
   a_alarm_pump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.low_water_alarm) |-> !rsp_ff.pump_on)
      else $error("alarm reported with pump on");
`endif

endmodule

// File: hw/rtl/ifc_csr.sv
// ----------------------------------------------------------------------------
// ifc_csr
// Configuration registers: dry threshold, pump run time and cooldown.
// ----------------------------------------------------------------------------
module ifc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [ifc_pkg::CSR_INDEX_W-1:0]  wr_index,
   input  logic [ifc_pkg::CSR_DATA_W-1:0]   wr_data,
   output ifc_pkg::ifc_cfg_type             cfg
);
   import ifc_pkg::*;

   ifc_cfg_type cfg_ff;
   ifc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_DRY_THRESHOLD: cfg_in.dry_threshold    = wr_data[6:0];
            CSR_PUMP_DURATION: cfg_in.pump_duration_ms = wr_data;
            CSR_COOLDOWN:      cfg_in.cooldown_ms      = wr_data;
            default: ;  // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dry_threshold    <= DRY_THRESHOLD_RST;
         cfg_ff.pump_duration_ms <= PUMP_DURATION_RST;
         cfg_ff.cooldown_ms      <= COOLDOWN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/ifc_core.sv
// ----------------------------------------------------------------------------
// ifc_core
// Controller state and its next-state logic for one event per cycle while fire is high.
// ----------------------------------------------------------------------------
module ifc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  ifc_pkg::ifc_item_type   item,
   input  ifc_pkg::ifc_cfg_type    cfg,
   output ifc_pkg::ifc_result_type result
);
   import ifc_pkg::*;

   logic [1:0]  mode_ff,        mode_in;
   logic        pump_running_ff, pump_running_in;
   logic [31:0] start_stamp_ff, start_stamp_in;
   logic [31:0] stop_stamp_ff,  stop_stamp_in;
   logic [6:0]  fan_target_ff,  fan_target_in;
   logic [6:0]  fan_speed_ff,   fan_speed_in;
   logic        boost_done_ff,  boost_done_in;
   logic        alarm;

   logic [15:0] run_limit;
   logic [31:0] run_elapsed;
   logic [31:0] rest_elapsed;
   logic        run_expired;
   logic        rest_over;
   logic [15:0] moist;
   logic [16:0] thr_full;
   logic [16:0] thr_eco;
   logic        dark;
   logic        water_due;
   logic [6:0]  speed_step;

   always_comb begin
      run_limit    = (mode_ff == MODE_SAVER) ? {1'b0, cfg.pump_duration_ms[15:1]}
                                             : cfg.pump_duration_ms;
      run_elapsed  = item.now_ms - start_stamp_ff;
      rest_elapsed = item.now_ms - stop_stamp_ff;
      run_expired  = (run_elapsed >= 32'(run_limit));
      // a pump stopped in this step has zero rest, so the old stamp decides
      rest_over    = (rest_elapsed > 32'(cfg.cooldown_ms));

      moist    = moist_scaled(item.moist_sample);
      thr_full = thr_scaled(cfg.dry_threshold);
      thr_eco  = thr_scaled(cfg.dry_threshold - 7'(ECO_MARGIN));
      dark     = is_evening(item.light_sample);

      case (mode_ff)
         MODE_NORMAL: water_due = (17'(moist) < thr_full);
         MODE_SAVER: water_due =
            ((cfg.dry_threshold >= 7'(ECO_MARGIN)) && (17'(moist) < thr_eco)) ||
            ((17'(moist) < thr_full) && dark);
         default: water_due = 1'b0;
      endcase

      if (fan_speed_ff < fan_target_ff)
         speed_step = fan_speed_ff + 7'd1;
      else if (fan_speed_ff > fan_target_ff)
         speed_step = fan_speed_ff - 7'd1;
      else
         speed_step = fan_speed_ff;
   end

   always_comb begin
      mode_in         = mode_ff;
      pump_running_in = pump_running_ff;
      start_stamp_in  = start_stamp_ff;
      stop_stamp_in   = stop_stamp_ff;
      fan_target_in   = fan_target_ff;
      fan_speed_in    = fan_speed_ff;
      boost_done_in   = boost_done_ff;
      alarm           = 1'b0;

      case (item.kind)
         KIND_CONTROL: begin
            fan_target_in = fan_target_of(mode_ff, item.temperature);
            if (pump_running_ff && run_expired) begin
               pump_running_in = 1'b0;
               stop_stamp_in   = item.now_ms;
            end
            if (!pump_running_ff && (mode_ff != MODE_OFF) && rest_over && water_due) begin
               if (item.water_present) begin
                  pump_running_in = 1'b1;
                  start_stamp_in  = item.now_ms;
               end else begin
                  alarm = 1'b1;
               end
            end
         end
         KIND_RAMP: begin
            if ((fan_speed_ff == 7'd0) && (fan_target_ff != 7'd0) && !boost_done_ff) begin
               fan_speed_in  = FAN_FULL;
               boost_done_in = 1'b1;
            end else begin
               fan_speed_in = speed_step;
               if ((fan_target_ff == 7'd0) && (speed_step == 7'd0))
                  boost_done_in = 1'b0;
            end
         end
         KIND_TOGGLE: begin
            if (mode_ff == MODE_OFF) begin
               mode_in = MODE_NORMAL;
            end else begin
               mode_in         = MODE_OFF;
               pump_running_in = 1'b0;
               stop_stamp_in   = item.now_ms;
               fan_target_in   = 7'd0;
               fan_speed_in    = 7'd0;
            end
         end
         KIND_ECO: begin
            mode_in = MODE_SAVER;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_OFF;
         pump_running_ff <= 1'b0;
         start_stamp_ff  <= 32'd0;
         stop_stamp_ff   <= 32'd0;
         fan_target_ff   <= 7'd0;
         fan_speed_ff    <= 7'd0;
         boost_done_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff         <= mode_in;
         pump_running_ff <= pump_running_in;
         start_stamp_ff  <= start_stamp_in;
         stop_stamp_ff   <= stop_stamp_in;
         fan_target_ff   <= fan_target_in;
         fan_speed_ff    <= fan_speed_in;
         boost_done_ff   <= boost_done_in;
      end
   end

   assign result.pump_on         = pump_running_in;
   assign result.fan_percent     = fan_speed_in;
   assign result.mode            = mode_in;
   assign result.low_water_alarm = alarm;

`ifndef SYNTHESIS
   // fan never runs past full speed
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      fan_speed_ff <= FAN_FULL)
      else $error("fan speed above full scale");

   // target only takes one of the temperature steps
   a_target_steps: assert property (@(posedge clock) disable iff (reset)
      fan_target_ff == 7'd0 || fan_target_ff == FAN_LOW ||
      fan_target_ff == FAN_MID || fan_target_ff == FAN_FULL)
      else $error("fan target off its step set");

   // the pump only runs while the system is on
   a_pump_needs_mode: assert property (@(posedge clock) disable iff (reset)
      pump_running_ff |-> (mode_ff != MODE_OFF))
      else $error("pump running while system off");

   // an alarm step never starts the pump
   a_alarm_no_start: assert property (@(posedge clock) disable iff (reset)
      (fire && alarm) |=> !pump_running_ff)
      else $error("pump started on a low-water step");
`endif

endmodule
